@@ rtl/d2c_pkg.sv @@
// ---------------------------------------------------------------------------
// d2c_pkg
// Shared types and constants for the dense to CSR threshold converter.
// ---------------------------------------------------------------------------
package d2c_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int MAX_ENTRIES = 1024;
   localparam int VALUE_W     = 32;

   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int CNT_W    = 7;
   localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
   localparam int PTR_W    = 11;
   localparam int THR_W    = 31;
   localparam int OCOL_W   = 7;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 31;
   localparam int KIND_W   = 3;
   localparam int QDEPTH   = 3;

   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_COLUMNS   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_ROWS      = 2'd2;

   localparam logic [CNT_W-1:0]  CNT_MAX_COLS = CNT_W'(MAX_COLS);
   localparam logic [CNT_W-1:0]  CNT_MAX_ROWS = CNT_W'(MAX_ROWS);
   localparam logic [PTR_W-1:0]  PTR_MAX_ENTRIES = PTR_W'(MAX_ENTRIES);
   localparam logic [OCOL_W-1:0] COL_SENTINEL = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENTRY = 3'd0,
      KIND_ROW   = 3'd1,
      KIND_TERM  = 3'd2,
      KIND_HIT   = 3'd3,
      KIND_MISS  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic [OCOL_W-1:0]  column;
      logic [CNT_W-1:0]   nonzeros;
      logic [PTR_W-1:0]   pointer;
      logic               overflow;
      logic               last;
   } rsp_type;

   // Results of one item, packed from slot 0 up; count is how many are valid.
   typedef struct packed {
      logic [1:0]          count;
      rsp_type [QDEPTH-1:0] slot;
   } push_type;

endpackage

@@ rtl/d2c_rsp_queue.sv @@
// ---------------------------------------------------------------------------
// d2c_rsp_queue
// Holds the up to three results of one item and feeds them, in order,
// through a registered output stage.
// ---------------------------------------------------------------------------
module d2c_rsp_queue
   import d2c_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // out_value, out_column, row_nonzeros,
                                     // row_pointer, overflow, zero fill
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast
);

   rsp_type    q_ff [QDEPTH];
   rsp_type    q_in [QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       pop;

   always_comb begin
      pop          = (cnt_ff != 2'd0) && (!out_valid_ff || rsp_tready);
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         out_in       = q_ff[0];
         out_valid_in = 1'b1;
         q_in[0]      = q_ff[1];
         q_in[1]      = q_ff[2];
         cnt_in       = cnt_ff - 2'd1;
      end
      // A push only comes when the queue is empty after this cycle's pop.
      if (push.count != 2'd0) begin
         q_in[0] = push.slot[0];
         q_in[1] = push.slot[1];
         q_in[2] = push.slot[2];
         cnt_in  = push.count;
      end
      free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      q_ff   <= q_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {6'd0, out_ff.overflow, out_ff.pointer, out_ff.nonzeros,
                        out_ff.column, out_ff.value};

endmodule

@@ rtl/dense_to_csr_threshold.sv @@
// ---------------------------------------------------------------------------
// dense_to_csr_threshold
// Converts a row-major dense matrix into compressed sparse row form and
// answers lookups by walking one stored row.
// ---------------------------------------------------------------------------
// Loads: results pass through the response queue and the output register;
// a new item waits until the queue drains, so a stalled output holds back
// further items. Lookups read the row record, then walk its entries in order
// until the column matches (hit) or the row ends (miss); an empty row is
// answered from the row record alone, a row not yet finished at once (miss).
// Reset clears control state but not the walk registers or the memories.
module dense_to_csr_threshold
   import d2c_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,   // element_value, lookup_row,
                                           // lookup_col, zero fill
   input  logic [0:0]         req_tuser,   // action
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // out_value, out_column, row_nonzeros,
                                           // row_pointer, overflow, zero fill
   output logic [2:0]         rsp_tuser,   // kind
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_addr,
   input  logic [CSR_DW-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ROW  = 3'b010,
      ST_WALK = 3'b100
   } state_type;

   // Configuration registers.
   logic [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0] colcnt_ff;
   logic [CNT_W-1:0] rowcnt_ff;

   // Conversion state.
   logic [CNT_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [CNT_W-1:0] row_kept_ff, row_kept_in;
   logic [PTR_W-1:0] row_first_ff, row_first_in;
   logic [PTR_W-1:0] total_ff, total_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;

   // Lookup walk.
   state_type            state_ff, state_in;
   logic [COL_W-1:0]     look_col_ff, look_col_in;
   logic [ENTRY_AW-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]     walk_cnt_ff, walk_cnt_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 dvalid_ff, dvalid_in;

   // Memories: entries hold {column, value}, rows hold {start, count}.
   logic [COL_W+VALUE_W-1:0] entry_mem [MAX_ENTRIES];
   logic [PTR_W+CNT_W-1:0]   row_mem [MAX_ROWS];
   logic [COL_W+VALUE_W-1:0] entry_rdata;
   logic [PTR_W+CNT_W-1:0]   row_rdata;
   logic                     entry_we, row_we;
   logic [ENTRY_AW-1:0]      entry_waddr, entry_raddr;
   logic [ROW_AW-1:0]        row_waddr, row_raddr;
   logic [PTR_W+CNT_W-1:0]   row_wdata;

   // Input fields.
   logic                  in_action;
   logic [VALUE_W-1:0]    in_value;
   logic [ROW_AW-1:0]     in_row;
   logic [COL_W-1:0]      in_col;
   logic                  accept;

   // Load datapath.
   logic [VALUE_W-1:0]    neg;
   logic [THR_W-1:0]      mag;
   logic                  keep, store;
   logic [CNT_W-1:0]      cols, rows;
   logic                  row_end, term;
   logic [PTR_W-1:0]      total_new, row_first_new;
   logic [CNT_W-1:0]      row_kept_new;
   logic                  ovf_new;
   rsp_type               r_entry, r_row, r_term, r_look;
   logic [1:0]            n_res;

   // Walk datapath.
   logic [CNT_W-1:0]      rd_cnt;
   logic [PTR_W-1:0]      rd_start;
   logic [PTR_W-1:0]      start_m1;
   logic                  issuing, match;

   push_type              push;
   logic                  q_free;

   assign in_action = req_tuser[0];
   assign in_value  = req_tdata[31:0];
   assign in_row    = req_tdata[37:32];
   assign in_col    = req_tdata[43:38];

   assign req_tready = (state_ff == ST_IDLE) && q_free;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         colcnt_ff <= CNT_MAX_COLS;
         rowcnt_ff <= CNT_MAX_ROWS;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD: thr_ff    <= csr_wdata;
            CSR_COLUMNS:   colcnt_ff <= csr_wdata[CNT_W-1:0];
            CSR_ROWS:      rowcnt_ff <= csr_wdata[CNT_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      // The most negative value has no positive twin; its magnitude saturates.
      neg = ~in_value + VALUE_W'(1);
      if (!in_value[VALUE_W-1]) begin
         mag = in_value[THR_W-1:0];
      end else if (in_value[VALUE_W-2:0] == '0) begin
         mag = '1;
      end else begin
         mag = neg[THR_W-1:0];
      end
      keep  = mag >= thr_ff;
      store = keep && (total_ff < PTR_MAX_ENTRIES);

      total_new     = total_ff + PTR_W'(store);
      row_kept_new  = row_kept_ff + CNT_W'(store);
      row_first_new = (store && (row_first_ff == '0)) ? total_new : row_first_ff;
      ovf_new       = ovf_ff || (keep && !store);

      if (colcnt_ff == '0)               cols = CNT_W'(1);
      else if (colcnt_ff > CNT_MAX_COLS) cols = CNT_MAX_COLS;
      else                               cols = colcnt_ff;
      if (rowcnt_ff == '0)               rows = CNT_W'(1);
      else if (rowcnt_ff > CNT_MAX_ROWS) rows = CNT_MAX_ROWS;
      else                               rows = rowcnt_ff;

      row_end = ({1'b0, cur_col_ff} + CNT_W'(1)) >= cols;
      term    = row_end && ((cur_row_ff + CNT_W'(1)) >= rows);

      r_entry = '{kind: KIND_ENTRY, value: in_value, column: {1'b0, cur_col_ff},
                  nonzeros: '0, pointer: '0, overflow: ovf_new, last: 1'b0};
      r_row   = '{kind: KIND_ROW, value: '0, column: '0, nonzeros: row_kept_new,
                  pointer: row_first_new, overflow: ovf_new, last: 1'b0};
      r_term  = '{kind: KIND_TERM, value: '0, column: COL_SENTINEL, nonzeros: '0,
                  pointer: total_new + PTR_W'(1), overflow: ovf_new, last: 1'b1};
      if (!row_end) r_entry.last = 1'b1;
      if (!term)    r_row.last   = 1'b1;
      n_res = 2'(store) + 2'(row_end) + 2'(term);
   end

   always_comb begin
      rd_cnt   = row_rdata[CNT_W-1:0];
      rd_start = row_rdata[PTR_W+CNT_W-1:CNT_W];
      start_m1 = rd_start - PTR_W'(1);
      issuing  = issue_ff < walk_cnt_ff;
      match    = dvalid_ff && (entry_rdata[COL_W+VALUE_W-1:VALUE_W] == look_col_ff);
      r_look   = '{kind: match ? KIND_HIT : KIND_MISS,
                   value: match ? entry_rdata[VALUE_W-1:0] : '0,
                   column: {1'b0, look_col_ff}, nonzeros: '0, pointer: '0,
                   overflow: ovf_ff, last: 1'b1};
   end

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      row_kept_in  = row_kept_ff;
      row_first_in = row_first_ff;
      total_in     = total_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      look_col_in  = look_col_ff;
      base_in      = base_ff;
      walk_cnt_in  = walk_cnt_ff;
      issue_in     = issue_ff;
      dvalid_in    = 1'b0;
      push         = '0;
      entry_we     = 1'b0;
      row_we       = 1'b0;
      entry_waddr  = total_ff[ENTRY_AW-1:0];
      row_waddr    = cur_row_ff[ROW_AW-1:0];
      row_wdata    = {row_first_new, row_kept_new};
      row_raddr    = in_row;
      entry_raddr  = base_ff + ENTRY_AW'(issue_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !in_action && !done_ff) begin
               entry_we     = store;
               total_in     = total_new;
               ovf_in       = ovf_new;
               row_kept_in  = row_kept_new;
               row_first_in = row_first_new;
               cur_col_in   = cur_col_ff + COL_W'(1);
               if (row_end) begin
                  row_we       = 1'b1;
                  row_kept_in  = '0;
                  row_first_in = '0;
                  cur_col_in   = '0;
                  cur_row_in   = cur_row_ff + CNT_W'(1);
                  done_in      = term;
               end
               push.count   = n_res;
               push.slot[0] = store ? r_entry : r_row;
               push.slot[1] = store ? r_row : r_term;
               push.slot[2] = r_term;
            end else if (accept && in_action) begin
               look_col_in = in_col;
               if ({1'b0, in_row} < cur_row_ff) begin
                  state_in = ST_ROW;
               end else begin
                  push.count   = 2'd1;
                  push.slot[0] = '{kind: KIND_MISS, value: '0,
                                   column: {1'b0, in_col}, nonzeros: '0,
                                   pointer: '0, overflow: ovf_ff, last: 1'b1};
               end
            end
         end
         ST_ROW: begin
            if (rd_cnt == '0) begin
               push.count   = 2'd1;
               push.slot[0] = r_look;
               state_in     = ST_IDLE;
            end else begin
               base_in     = start_m1[ENTRY_AW-1:0];
               walk_cnt_in = rd_cnt;
               issue_in    = '0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            // One read issued per cycle; its data is compared in the cycle after.
            if (match || (dvalid_ff && !issuing)) begin
               push.count   = 2'd1;
               push.slot[0] = r_look;
               state_in     = ST_IDLE;
            end else if (issuing) begin
               dvalid_in = 1'b1;
               issue_in  = issue_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Loads write and lookups read in different states, so no access to an
   // entry can overlap with a write to it.
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= {cur_col_ff, in_value};
      end
      entry_rdata <= entry_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rdata <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         row_kept_ff  <= '0;
         row_first_ff <= '0;
         total_ff     <= '0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         dvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         row_kept_ff  <= row_kept_in;
         row_first_ff <= row_first_in;
         total_ff     <= total_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         dvalid_ff    <= dvalid_in;
      end
      look_col_ff <= look_col_in;
      base_ff     <= base_in;
      walk_cnt_ff <= walk_cnt_in;
      issue_ff    <= issue_in;
   end

   d2c_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free       (q_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
